[hdl/sstm_pkg.sv]
// Shared types and constants for the sorted series tolerance matcher.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package sstm_pkg;

  localparam int T_W    = 48;
  localparam int D_W    = 47;
  localparam int H_W    = 49;
  localparam int ALU_W  = 50;
  localparam int IDX_W  = 13;
  localparam int STAT_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK           = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FIRST_ORDER  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SECOND_ORDER = 2'd2;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_DELTA   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAREST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUP     = 2'd2;

  typedef struct packed {
    logic [D_W-1:0] delta;
    logic           nearest_mode;
    logic           allow_duplicates;
  } sstm_cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]  match_index;
    logic [STAT_W-1:0] status;
  } sstm_result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ORD,
    ST_LO,
    ST_HI,
    ST_SADDR,
    ST_SCHK,
    ST_SLO,
    ST_MHI,
    ST_DA,
    ST_DB,
    ST_NADDR,
    ST_NCHK,
    ST_NHI,
    ST_NBEST,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

[hdl/sstm_alu.sv]
// Shared add/subtract unit; its sign bit serves every ordering compare.
// Depends on sstm_pkg for the operand width.
`timescale 1ns / 1ps
`default_nettype none

module sstm_alu (
  input  wire logic signed [sstm_pkg::ALU_W-1:0] a,
  input  wire logic signed [sstm_pkg::ALU_W-1:0] b,
  input  wire logic                              sub,
  output logic signed [sstm_pkg::ALU_W-1:0]      sum,
  output logic                                   neg
);
  import sstm_pkg::*;

  logic [ALU_W-1:0] b_op;

  always_comb begin
    b_op = sub ? ~b : b;
    sum  = a + b_op + ALU_W'(sub);
    neg  = sum[ALU_W-1];
  end

endmodule

`default_nettype wire

[hdl/sstm_store.sv]
// Second-series time store: one write port and one registered read port.
// Depends on sstm_pkg for the time width.
`timescale 1ns / 1ps
`default_nettype none

module sstm_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [AW-1:0]                    waddr,
  input  wire logic signed [sstm_pkg::T_W-1:0]  wdata,
  input  wire logic [AW-1:0]                    raddr,
  output logic signed [sstm_pkg::T_W-1:0]       rdata
);
  import sstm_pkg::*;

  logic [T_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/sstm_seq.sv]
// Sequencer and datapath registers of the matcher: loads, the forward scan and
// the nearest walk, all through one shared add/subtract unit.
// Depends on sstm_pkg and sstm_alu.
`timescale 1ns / 1ps
`default_nettype none

module sstm_seq #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int CW    = 13
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              req_type,
  input  wire logic signed [sstm_pkg::T_W-1:0]   time_value,
  input  wire logic                              first_of_set,
  input  wire sstm_pkg::sstm_cfg_t               cfg,
  output logic                                   res_valid,
  input  wire logic                              res_ready,
  output sstm_pkg::sstm_result_t                 res,
  output logic                                   mem_we,
  output logic [AW-1:0]                          mem_waddr,
  output logic signed [sstm_pkg::T_W-1:0]        mem_wdata,
  output logic [AW-1:0]                          mem_raddr,
  input  wire logic signed [sstm_pkg::T_W-1:0]   mem_rdata
);
  import sstm_pkg::*;

  state_t state;
  state_t state_next;

  logic                    first_q;
  logic signed [T_W-1:0]   tq;
  logic [CW-1:0]           count;
  logic [CW-1:0]           sp;
  logic signed [T_W-1:0]   last_first;
  logic signed [T_W-1:0]   last_second;
  logic [STAT_W-1:0]       sticky;
  logic [STAT_W-1:0]       sticky_next;
  logic signed [T_W-1:0]   vreg;
  logic signed [H_W-1:0]   lo;
  logic signed [H_W-1:0]   hi;
  logic signed [H_W-1:0]   dreg;
  logic signed [H_W-1:0]   best;
  logic signed [H_W-1:0]   dmag;
  logic                    matched;
  logic                    walking;

  logic [CW-1:0]           jn;
  logic [CW-1:0]           cnt_base;
  logic [STAT_W-1:0]       flag_code;
  logic [STAT_W-1:0]       sticky_base;

  logic signed [ALU_W-1:0] alu_a;
  logic signed [ALU_W-1:0] alu_b;
  logic                    alu_sub;
  logic signed [ALU_W-1:0] alu_sum;
  logic                    alu_neg;

  sstm_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum),
    .neg (alu_neg)
  );

  assign jn       = sp + 1'b1;
  assign cnt_base = first_q ? '0 : count;
  assign dmag     = dreg[H_W-1] ? alu_sum[H_W-1:0] : dreg;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (req_type == REQ_LOAD) ? ST_LOAD : ST_ORD;
        end
      end
      ST_LOAD:  state_next = ST_IDLE;
      ST_ORD:   state_next = ST_LO;
      ST_LO:    state_next = ST_HI;
      ST_HI:    state_next = ST_SADDR;
      ST_SADDR: state_next = (sp < count) ? ST_SCHK : ST_FIN;
      ST_SCHK:  state_next = ST_SLO;
      ST_SLO:   state_next = alu_neg ? ST_SADDR : ST_MHI;
      ST_MHI: begin
        if (alu_neg || !cfg.nearest_mode) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_DA;
        end
      end
      ST_DA:    state_next = ST_DB;
      ST_DB:    state_next = walking ? ST_NBEST : ST_NADDR;
      ST_NADDR: state_next = (jn < count) ? ST_NCHK : ST_FIN;
      ST_NCHK:  state_next = ST_NHI;
      ST_NHI:   state_next = alu_neg ? ST_FIN : ST_DA;
      ST_NBEST: state_next = alu_neg ? ST_NADDR : ST_FIN;
      ST_FIN:   state_next = res_ready ? ST_IDLE : ST_FIN;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    alu_a     = ALU_W'(tq);
    alu_b     = ALU_W'(last_first);
    alu_sub   = 1'b1;
    flag_code = STAT_OK;
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_raddr = sp[AW-1:0];
    res_valid = 1'b0;
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_LOAD: begin
        mem_we = (cnt_base < CW'(DEPTH));
        if (!mem_we) begin
          flag_code = STAT_OVERFLOW;
        end
      end
      ST_ORD: begin
        if (alu_neg) begin
          flag_code = STAT_FIRST_ORDER;
        end
      end
      ST_LO: alu_b = ALU_W'(cfg.delta);
      ST_HI: begin
        alu_b   = ALU_W'(cfg.delta);
        alu_sub = 1'b0;
      end
      ST_SADDR: mem_raddr = sp[AW-1:0];
      ST_SCHK, ST_NCHK: begin
        alu_a = ALU_W'(mem_rdata);
        alu_b = ALU_W'(last_second);
        if (alu_neg) begin
          flag_code = STAT_SECOND_ORDER;
        end
      end
      ST_SLO: begin
        alu_a = ALU_W'(vreg);
        alu_b = ALU_W'(lo);
      end
      ST_MHI, ST_NHI: begin
        alu_a = ALU_W'(hi);
        alu_b = ALU_W'(vreg);
      end
      ST_DA: begin
        alu_a = ALU_W'(vreg);
        alu_b = ALU_W'(tq);
      end
      ST_DB: begin
        alu_a = ALU_W'(tq);
        alu_b = ALU_W'(vreg);
      end
      ST_NADDR: mem_raddr = jn[AW-1:0];
      ST_NBEST: begin
        alu_a = ALU_W'(dreg);
        alu_b = ALU_W'(best);
      end
      ST_FIN: res_valid = 1'b1;
      default: ;
    endcase
    sticky_base = (state == ST_LOAD && first_q) ? STAT_OK : sticky;
    sticky_next = (sticky_base == STAT_OK) ? flag_code : sticky_base;
  end

  assign mem_waddr       = cnt_base[AW-1:0];
  assign mem_wdata       = tq;
  assign res.match_index = matched ? IDX_W'(jn) : '0;
  assign res.status      = sticky;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      sp          <= '0;
      last_first  <= T_MIN;
      last_second <= T_MIN;
      sticky      <= STAT_OK;
      matched     <= 1'b0;
      walking     <= 1'b0;
    end else begin
      state  <= state_next;
      sticky <= sticky_next;
      case (state)
        ST_IDLE: begin
          matched <= 1'b0;
          walking <= 1'b0;
        end
        ST_LOAD: begin
          if (first_q) begin
            sp          <= '0;
            last_first  <= T_MIN;
            last_second <= T_MIN;
          end
          count <= mem_we ? cnt_base + 1'b1 : cnt_base;
        end
        ST_ORD:  last_first <= tq;
        ST_SCHK: last_second <= mem_rdata;
        ST_SLO: begin
          if (alu_neg) begin
            sp <= jn;
          end
        end
        ST_MHI: begin
          if (!alu_neg) begin
            matched <= 1'b1;
          end
        end
        ST_DB: walking <= 1'b1;
        ST_NBEST: begin
          if (alu_neg) begin
            sp          <= jn;
            last_second <= vreg;
          end
        end
        ST_FIN: begin
          if (res_ready && matched && !cfg.allow_duplicates) begin
            sp <= jn;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          tq      <= time_value;
          first_q <= first_of_set;
        end
      end
      ST_LO:   lo <= alu_sum[H_W-1:0];
      ST_HI:   hi <= alu_sum[H_W-1:0];
      ST_SCHK, ST_NCHK: vreg <= mem_rdata;
      ST_DA:   dreg <= alu_sum[H_W-1:0];
      ST_DB: begin
        if (walking) begin
          dreg <= dmag;
        end else begin
          best <= dmag;
        end
      end
      ST_NBEST: begin
        if (alu_neg) begin
          best <= dreg;
        end
      end
      default: ;
    endcase
  end

  a_sp_bound: assert property (@(posedge clk) disable iff (rst) sp <= count)
    else $error("scan position passed the stored count");

  a_sticky_hold: assert property (@(posedge clk) disable iff (rst)
    (sticky != STAT_OK && !(state == ST_LOAD && first_q)) |=> sticky == $past(sticky))
    else $error("sticky status changed without a set start");

  a_sp_forward: assert property (@(posedge clk) disable iff (rst)
    !(state == ST_LOAD && first_q) |=> sp >= $past(sp))
    else $error("scan position moved backward");

  a_load_count: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> count == CW'($past(mem_waddr)) + 1'b1)
    else $error("stored count does not follow the written entry");

endmodule

`default_nettype wire

[hdl/sorted_series_tolerance_match_core.sv]
// Top level of the sorted series tolerance matcher: configuration registers,
// the result register and the store. Depends on sstm_pkg, sstm_seq, sstm_store.
//
// Requests enter on in_valid/in_stall. A load request (req_type 0) appends
// time_value to the store; first_of_set on a load first clears the count, the
// scan position, the last-seen times and the status. A query request
// (req_type 1) yields one result on out_valid/out_stall: the 1-based index of
// the matched stored time, or 0, and the sticky status.
// A load appends one entry unless the store is full. A query checks order,
// forms the low and high window bounds, then scans forward over the stored
// elements; in nearest mode a match leads to a walk onto later elements while
// each stays in the window and is strictly nearer. Every step uses one shared
// 50-bit add/subtract unit; a store read has an address and a data state.
// in_stall is high while a request is in progress. The result register lets
// the next request enter while a result still waits; a finished query waits
// while out_stall holds the previous result. Configuration writes on
// cfg_write/cfg_index/cfg_data take effect at once and are meant for idle time.
// Reset clears control state and the configuration; the store needs no clear.
`timescale 1ns / 1ps
`default_nettype none

module sorted_series_tolerance_match_core #(
  parameter int SERIES_DEPTH = 4096
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  req_type,
  input  wire logic signed [sstm_pkg::T_W-1:0]       time_value,
  input  wire logic                                  first_of_set,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [sstm_pkg::IDX_W-1:0]                 match_index,
  output logic [sstm_pkg::STAT_W-1:0]                status,
  input  wire logic                                  cfg_write,
  input  wire logic [sstm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [sstm_pkg::D_W-1:0]              cfg_data
);
  import sstm_pkg::*;

  localparam int AW = $clog2(SERIES_DEPTH);
  localparam int CW = $clog2(SERIES_DEPTH + 1);

  sstm_cfg_t    cfg;
  sstm_result_t res;
  logic         res_valid;
  logic         res_ready;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic signed [T_W-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic signed [T_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DELTA:   cfg.delta            <= cfg_data;
        CFG_NEAREST: cfg.nearest_mode     <= cfg_data[0];
        CFG_DUP:     cfg.allow_duplicates <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      match_index <= res.match_index;
      status      <= res.status;
    end
  end

  sstm_seq #(
    .DEPTH (SERIES_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .time_value   (time_value),
    .first_of_set (first_of_set),
    .cfg          (cfg),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  sstm_store #(
    .DEPTH (SERIES_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire
